/* design/lifo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_pkg: shared types and codes for the bounded LIFO stack with search
// Holds the payload structs, the action codes and the per-cell control group.
// ----------------------------------------------------------------------------
package lifo_pkg;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_EDIT   = 2'd3;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] data_value;
    logic [3:0]         edit_index;
  } lifo_in_t;

  typedef struct packed {
    logic               ignored;
    logic               found;
    logic [3:0]         found_position;
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [4:0]         fill_level;
  } lifo_out_t;

  // Broadcast controls that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic edit;
    logic load_match;
    logic shift_match;
  } lifo_cell_ctl_t;

endpackage

/* design/lifo_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_cell: one entry of the stack chain
// Holds one word, shifts it to or from its neighbors on push and pop, takes an
// edit aimed at it, and keeps a match bit that moves deeper down the chain on a scan.
// ----------------------------------------------------------------------------
module lifo_cell #(
  parameter int CW  = 5,
  parameter int AW  = 4,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lifo_pkg::lifo_cell_ctl_t ctl,
  input  logic signed [31:0]       key,
  input  logic signed [31:0]       shift_in,
  input  logic signed [31:0]       pop_in,
  input  logic                     match_in,
  input  logic [CW-1:0]            count,
  input  logic [AW-1:0]            edit_cell,
  output logic signed [31:0]       value,
  output logic                     match
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= shift_in;
    end else if (ctl.pop) begin
      value <= pop_in;
    end else if (ctl.edit && (edit_cell == AW'(IDX))) begin
      value <= key;
    end
  end

  // Only cells holding a live entry may report a match.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.load_match) begin
      match <= (value == key) && (CW'(IDX) < count);
    end else if (ctl.shift_match) begin
      match <= match_in;
    end
  end

endmodule

/* design/bounded_lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_search: bounded LIFO of signed words with search
// A chain of DEPTH cells with the top of stack in cell 0. Push, pop and edit
// finish in the cycle of the transfer; search loads per-cell match bits and
// then shifts them deeper down the chain to find the lowest matching position.
// ----------------------------------------------------------------------------
// Timing: push, pop and edit results are registered at the input transfer
//   and shown in the next cycle; a new item can follow while the output does not stall.
// Search: the match bits load at the transfer, then the match scan shifts
//   deeper through the chain one cell per cycle while the output does not stall.
// Reset: fill level 0, capacity 16, no result pending; entries are undefined
//   until pushed.
module bounded_lifo_stack_with_search #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lifo_pkg::lifo_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lifo_pkg::lifo_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  // Width of the fill count, of a cell address, and of the comparison spaces
  // used against the 5-bit capacity and the 4-bit edit index.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int MW = (CW > 5) ? CW : 5;
  localparam int EW = (CW > 4) ? CW : 4;
  localparam int PW = CW + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [4:0]    capacity;
  logic [AW-1:0] step;

  logic signed [31:0] cell_val   [DEPTH];
  logic               cell_match [DEPTH];

  lifo_pkg::lifo_cell_ctl_t ctl;
  lifo_pkg::lifo_out_t      result;

  logic          in_xfer;
  logic          out_busy;
  logic          load_out;
  logic          push_ok;
  logic          pop_ok;
  logic          edit_ok;
  logic [EW-1:0] edit_target;
  logic [AW-1:0] edit_cell;
  logic signed [31:0] key;
  logic signed [31:0] top_now;
  logic signed [31:0] top_after;
  logic          scan_hit;
  logic          scan_last;
  logic          scan_done;
  logic [PW-1:0] hit_pos;

  // --------------------------------------------------------------------------
  // Handshakes. The output register frees the input side as soon as the
  // pending result is being taken; a search holds the input until its scan
  // has delivered.
  // --------------------------------------------------------------------------
  assign out_busy  = out_valid && out_stall;
  assign in_stall  = (state == ST_SCAN) || out_busy;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign key = in_data.data_value;

  // A push needs room under both the programmed capacity and the chain
  // length; an edit must aim below the fill level.
  assign push_ok = (MW'(count) < MW'(capacity)) && (count < CW'(DEPTH));
  assign pop_ok  = (count != '0);
  assign edit_ok = (EW'(in_data.edit_index) < EW'(count));

  // Position p from the bottom lives in cell count-1-p.
  assign edit_target = EW'(count) - EW'(1) - EW'(in_data.edit_index);
  assign edit_cell   = edit_target[AW-1:0];

  always_comb begin
    ctl = '0;
    if (in_xfer) begin
      case (in_data.action)
        lifo_pkg::ACT_PUSH:   ctl.push       = push_ok;
        lifo_pkg::ACT_POP:    ctl.pop        = pop_ok;
        lifo_pkg::ACT_SEARCH: ctl.load_match = 1'b1;
        lifo_pkg::ACT_EDIT:   ctl.edit       = edit_ok;
        default:              ctl            = '0;
      endcase
    end
    if ((state == ST_SCAN) && !out_busy && !scan_done) begin
      ctl.shift_match = 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // The chain of cells. Cell 0 is the top of stack; a push shifts every word
  // one cell deeper, a pop pulls every word one cell up.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [31:0] shift_in;
    logic signed [31:0] pop_in;
    logic               match_in;

    if (k == 0) begin : g_first
      assign shift_in = key;
      assign match_in = 1'b0;
    end else begin : g_rest
      assign shift_in = cell_val[k-1];
      assign match_in = cell_match[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign pop_in = cell_val[k];
    end else begin : g_inner
      assign pop_in = cell_val[k+1];
    end

    lifo_cell #(
      .CW  (CW),
      .AW  (AW),
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .key       (key),
      .shift_in  (shift_in),
      .pop_in    (pop_in),
      .match_in  (match_in),
      .count     (count),
      .edit_cell (edit_cell),
      .value     (cell_val[k]),
      .match     (cell_match[k])
    );
  end

  // --------------------------------------------------------------------------
  // Top of stack after the action, taken from the cell contents before the
  // clock edge.
  // --------------------------------------------------------------------------
  assign top_now = pop_ok ? cell_val[0] : 32'sd0;

  always_comb begin
    top_after = top_now;
    if (ctl.push) begin
      top_after = key;
    end else if (ctl.pop) begin
      top_after = (count_next != '0) ? cell_val[1] : 32'sd0;
    end else if (ctl.edit && (edit_cell == '0)) begin
      top_after = key;
    end
  end

  // --------------------------------------------------------------------------
  // Search scan. The deepest cell is checked each cycle while match bits move
  // deeper down the chain, so the first hit is the deepest live match, which is the
  // lowest position from the bottom. At step s the bit seen started in cell
  // DEPTH-1-s, which is position count-DEPTH+s.
  // --------------------------------------------------------------------------
  assign scan_hit  = cell_match[DEPTH-1];
  assign scan_last = (step == AW'(DEPTH - 1));
  assign scan_done = scan_hit || scan_last;
  assign hit_pos   = PW'(count) + PW'(step) - PW'(DEPTH);

  always_comb begin
    result                = '0;
    result.top_value      = top_after;
    result.is_empty       = (count_next == '0);
    result.fill_level     = 5'(count_next);
    if (state == ST_SCAN) begin
      result.found          = scan_hit;
      result.found_position = scan_hit ? 4'(hit_pos) : 4'd0;
    end else if (in_data.action == lifo_pkg::ACT_PUSH) begin
      result.ignored = !push_ok;
    end else if (in_data.action == lifo_pkg::ACT_POP) begin
      result.ignored = !pop_ok;
    end else if (in_data.action == lifo_pkg::ACT_EDIT) begin
      result.ignored = !edit_ok;
    end
  end

  // A result enters the output register at the transfer of a push, pop or
  // edit, or when a search scan ends while the output side is free.
  assign load_out = (in_xfer && (in_data.action != lifo_pkg::ACT_SEARCH)) ||
                    ((state == ST_SCAN) && !out_busy && scan_done);

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      capacity  <= lifo_pkg::CAPACITY_RESET;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= load_out || out_busy;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && (in_data.action == lifo_pkg::ACT_SEARCH)) begin
            state <= ST_SCAN;
            step  <= '0;
          end
        end
        ST_SCAN: begin
          if (!out_busy) begin
            if (scan_done) begin
              state <= ST_IDLE;
            end else begin
              step <= step + AW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload is loaded only when a transfer into the output register
  // happens, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill level beyond chain length");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> in_stall)
    else $error("input taken during a search scan");

  a_push_into_empty: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_data.action == lifo_pkg::ACT_PUSH) && (count == '0) &&
     (capacity != 5'd0)) |=> ((count == CW'(1)) && (cell_val[0] == $past(key))))
    else $error("push into empty stack lost");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(in_xfer) && !$past(rst)) |-> (out_data.is_empty == (count == '0)))
    else $error("empty flag disagrees with fill level");

endmodule
